[hdl/cartridge_bank_mapper_macros.svh]
// Assertion helpers for the cartridge bank mapper.
// Both sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// Check a property with a fixed failure message.
`define CBM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("cartridge_bank_mapper: assertion failed");

// Check a property with a caller-supplied failure message.
`define CBM_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

[hdl/cbm_pkg.sv]
`timescale 1ns / 1ps

package cbm_pkg;

    // Default physical ROM address width
    localparam int ROM_ADDRESS_BITS = 21;
    localparam int MEM_ADDR_W       = 21;
    localparam int MIN_ROM_BITS     = 15;
    localparam int EXT_ROM_BITS     = 20;

    // Bus opcodes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ROM_SIZE_LOG2 = 1'b0;
    localparam logic CFG_RAM_SIZE_KIB  = 1'b1;
    localparam int   CFG_DATA_W        = 6;

    // CPU address map boundaries
    localparam logic [15:0] ADDR_RAM_EN_LAST = 16'h1FFF;
    localparam logic [15:0] ADDR_LOW_LAST    = 16'h3FFF;
    localparam logic [15:0] ADDR_HIGH_LAST   = 16'h5FFF;
    localparam logic [15:0] ADDR_MODE_LAST   = 16'h7FFF;
    localparam logic [15:0] ADDR_RAM_FIRST   = 16'hA000;
    localparam logic [15:0] ADDR_RAM_LAST    = 16'hBFFF;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [5:0] RAM_KIB_FULL   = 6'd32;
    localparam logic [5:0] RAM_KIB_SMALL  = 6'd8;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_ROM_RD  = 2'd1,
        KIND_RAM_RD  = 2'd2,
        KIND_RAM_WR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic        opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        t_kind                   access_kind;
        logic [MEM_ADDR_W-1:0]   memory_address;
        logic [7:0]              store_data;
    } t_rsp;

    typedef struct packed {
        logic       ram_enabled;
        logic [4:0] low_bank;
        logic [1:0] high_bank;
        logic       advanced_mode;
    } t_bank_state;

    typedef struct packed {
        logic [4:0] rom_size_log2;
        logic [5:0] ram_size_kib;
    } t_cfg;

endpackage

[hdl/cbm_req_if.sv]
`timescale 1ns / 1ps

interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, output opcode, output bus_address, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input bus_address, input write_data,
                    output ready);
endinterface

[hdl/cbm_rsp_if.sv]
`timescale 1ns / 1ps

interface cbm_rsp_if;
    logic                           valid;
    logic                           ready;
    cbm_pkg::t_kind                 access_kind;
    logic [cbm_pkg::MEM_ADDR_W-1:0] memory_address;
    logic [7:0]                     store_data;

    modport source (output valid, output access_kind, output memory_address,
                    output store_data, input ready);
    modport sink   (input valid, input access_kind, input memory_address,
                    input store_data, output ready);
endinterface

[hdl/cbm_decode.sv]
`timescale 1ns / 1ps

module cbm_decode #(
    parameter int ROM_ADDRESS_BITS = cbm_pkg::ROM_ADDRESS_BITS
) (
    input  cbm_pkg::t_cfg        i_cfg,
    input  cbm_pkg::t_bank_state i_state,
    input  cbm_pkg::t_req        i_req,
    output cbm_pkg::t_bank_state o_next_state,
    output cbm_pkg::t_rsp        o_rsp
);

    localparam int MW = cbm_pkg::MEM_ADDR_W;

    logic [4:0]    rom_bits;
    logic          rom_ext;
    logic [MW:0]   rom_span;
    logic [MW-1:0] rom_mask;
    logic [7:0]    bank_span;
    logic [4:0]    low_mask;
    logic [1:0]    high_mask;
    logic [15:0]   addr;
    logic [7:0]    wdata;
    logic          in_ram_area;
    logic [1:0]    ram_high;
    logic [MW-1:0] ram_addr;
    logic [MW-1:0] rom_addr;

    // Clamp ROM size and derive the bank masks
    always_comb begin
        if (i_cfg.rom_size_log2 < 5'(cbm_pkg::MIN_ROM_BITS)) begin
            rom_bits = 5'(cbm_pkg::MIN_ROM_BITS);
        end else if (i_cfg.rom_size_log2 > 5'(ROM_ADDRESS_BITS)) begin
            rom_bits = 5'(ROM_ADDRESS_BITS);
        end else begin
            rom_bits = i_cfg.rom_size_log2;
        end
        rom_ext   = (rom_bits >= 5'(cbm_pkg::EXT_ROM_BITS));
        rom_span  = (MW+1)'(1) << rom_bits;
        rom_mask  = MW'(rom_span - (MW+1)'(1));
        bank_span = 8'(1) << (rom_bits - 5'd14);
        low_mask  = 5'(bank_span - 8'd1);
        // Upper bank bits exist only on the two extended sizes
        if (rom_bits == 5'(cbm_pkg::EXT_ROM_BITS + 1)) begin
            high_mask = 2'b11;
        end else if (rom_bits == 5'(cbm_pkg::EXT_ROM_BITS)) begin
            high_mask = 2'b01;
        end else begin
            high_mask = 2'b00;
        end
    end

    // Form the candidate physical addresses
    always_comb begin
        addr        = i_req.bus_address;
        wdata       = i_req.write_data;
        in_ram_area = (addr >= cbm_pkg::ADDR_RAM_FIRST) && (addr <= cbm_pkg::ADDR_RAM_LAST)
                      && i_state.ram_enabled;
        ram_high    = (i_state.advanced_mode && !rom_ext) ? i_state.high_bank : 2'b00;
        ram_addr    = MW'({ram_high, addr[12:0]});
        if (addr <= cbm_pkg::ADDR_LOW_LAST) begin
            rom_addr = {((i_state.advanced_mode && rom_ext) ? i_state.high_bank : 2'b00),
                        5'd0, addr[13:0]} & rom_mask;
        end else begin
            rom_addr = {i_state.high_bank, i_state.low_bank, addr[13:0]} & rom_mask;
        end
    end

    // Update bank registers and classify the access
    always_comb begin
        o_next_state = i_state;
        o_rsp.access_kind    = cbm_pkg::KIND_NONE;
        o_rsp.memory_address = '0;
        o_rsp.store_data     = '0;
        if (i_req.opcode == cbm_pkg::OP_WRITE) begin
            if (addr <= cbm_pkg::ADDR_RAM_EN_LAST) begin
                o_next_state.ram_enabled = (wdata[3:0] == cbm_pkg::RAM_ENABLE_KEY);
            end else if (addr <= cbm_pkg::ADDR_LOW_LAST) begin
                // Bank zero selects bank one
                o_next_state.low_bank = (wdata[4:0] == 5'd0) ? 5'd1 : (wdata[4:0] & low_mask);
            end else if (addr <= cbm_pkg::ADDR_HIGH_LAST) begin
                if (i_cfg.ram_size_kib == cbm_pkg::RAM_KIB_FULL) begin
                    o_next_state.high_bank = wdata[1:0];
                end else if (rom_ext) begin
                    o_next_state.high_bank = wdata[1:0] & high_mask;
                end
            end else if (addr <= cbm_pkg::ADDR_MODE_LAST) begin
                if ((i_cfg.ram_size_kib > cbm_pkg::RAM_KIB_SMALL) || rom_ext) begin
                    o_next_state.advanced_mode = (wdata != 8'd0);
                end
            end else if (in_ram_area) begin
                o_rsp.access_kind    = cbm_pkg::KIND_RAM_WR;
                o_rsp.memory_address = ram_addr;
                o_rsp.store_data     = wdata;
            end
        end else begin
            if (addr <= cbm_pkg::ADDR_MODE_LAST) begin
                o_rsp.access_kind    = cbm_pkg::KIND_ROM_RD;
                o_rsp.memory_address = rom_addr;
            end else if (in_ram_area) begin
                o_rsp.access_kind    = cbm_pkg::KIND_RAM_RD;
                o_rsp.memory_address = ram_addr;
            end
        end
    end

endmodule

[hdl/cartridge_bank_mapper.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Handshake     | Payload
// ---------+-----+---------------+-------------------------------------------
// i_req    | in  | valid / ready | opcode, bus_address, write_data
// o_rsp    | out | valid / ready | access_kind, memory_address, store_data
// i_cfg_*  | in  | write enable  | i_cfg_index, i_cfg_data
//
// One access per cycle while i_req.ready is high; a result appears in the cycle after its
// transfer when the result register is free, and waits behind the result ahead of it otherwise.
// Bank registers update at the input transfer, so the decode sees them in order.
// A result register plus one skid entry keep input transfers flowing while a
// result waits; i_req.ready drops only when the skid entry is full.
// Synchronous active-low reset returns bank state and configuration to defaults and clears both valids.

`include "cartridge_bank_mapper_macros.svh"

module cartridge_bank_mapper #(
    parameter int ROM_ADDRESS_BITS = cbm_pkg::ROM_ADDRESS_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cbm_req_if.sink                      i_req,
    cbm_rsp_if.source                    o_rsp
);

    cbm_pkg::t_cfg        r_cfg;
    cbm_pkg::t_bank_state r_state;
    cbm_pkg::t_bank_state n_state;
    cbm_pkg::t_req        req;
    cbm_pkg::t_rsp        n_rsp;
    cbm_pkg::t_rsp        r_out;
    cbm_pkg::t_rsp        r_skid;
    logic                 r_out_valid;
    logic                 r_skid_valid;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 out_is_none;
    logic                 out_payload_zero;
    logic                 out_waiting;

    assign req.opcode      = i_req.opcode;
    assign req.bus_address = i_req.bus_address;
    assign req.write_data  = i_req.write_data;

    assign i_req.ready = !r_skid_valid;
    assign in_xfer     = i_req.valid && !r_skid_valid;
    assign out_xfer    = r_out_valid && o_rsp.ready;

    cbm_decode #(
        .ROM_ADDRESS_BITS(ROM_ADDRESS_BITS)
    ) u_decode (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_req       (req),
        .o_next_state(n_state),
        .o_rsp       (n_rsp)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_size_log2 <= 5'(cbm_pkg::MIN_ROM_BITS);
            r_cfg.ram_size_kib  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbm_pkg::CFG_ROM_SIZE_LOG2: r_cfg.rom_size_log2 <= i_cfg_data[4:0];
                cbm_pkg::CFG_RAM_SIZE_KIB:  r_cfg.ram_size_kib  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bank state advances on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.ram_enabled   <= 1'b0;
            r_state.low_bank      <= 5'd1;
            r_state.high_bank     <= 2'd0;
            r_state.advanced_mode <= 1'b0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Result register and skid entry valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_xfer) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result payloads: refill from skid first, else load a new result, parked in skid while a result waits
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_xfer) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_xfer) begin
                r_out <= n_rsp;
            end
        end else if (in_xfer) begin
            r_skid <= n_rsp;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.access_kind    = r_out.access_kind;
    assign o_rsp.memory_address = r_out.memory_address;
    assign o_rsp.store_data     = r_out.store_data;

    // Terms for the checks
    assign out_is_none      = r_out_valid && (r_out.access_kind == cbm_pkg::KIND_NONE);
    assign out_payload_zero = (r_out.memory_address == '0) && (r_out.store_data == '0);
    assign out_waiting      = r_out_valid && !o_rsp.ready;

    // Checks
    `CBM_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid)
    `CBM_ASSERT(a_xfer_fills_out, (in_xfer && !r_out_valid) |=> r_out_valid)
    `CBM_ASSERT_MSG(a_none_is_zero, out_is_none |-> out_payload_zero, "cbm: payload on kind none")
    `CBM_ASSERT_MSG(a_out_held, out_waiting |=> (r_out_valid && $stable(r_out)), "cbm: result moved")

endmodule
